@@ src/bis_pkg.sv @@
// ----------------------------------------------------------------------------
// bis_pkg
// Shared constants, codes and request types of the bilinear image scaler.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int CoordW    = 12;   // column / row fields
  localparam int PixW      = 8;    // gray value
  localparam int SrcRegW   = 9;    // src_width / src_height registers
  localparam int DstRegW   = 13;   // dst_width / dst_height registers
  localparam int CfgDataW  = 13;   // widest register
  localparam int CfgIdxW   = 2;
  localparam int DstMax    = 4096;

  localparam int DefMaxSrcWidth  = 256;
  localparam int DefMaxSrcHeight = 256;
  localparam int DefFracBits     = 8;

  localparam logic [SrcRegW-1:0] SrcWidthRst  = SrcRegW'(256);
  localparam logic [SrcRegW-1:0] SrcHeightRst = SrcRegW'(256);
  localparam logic [DstRegW-1:0] DstWidthRst  = DstRegW'(512);
  localparam logic [DstRegW-1:0] DstHeightRst = DstRegW'(512);

  typedef enum logic [CfgIdxW-1:0] {
    CfgSrcWidth  = 2'd0,
    CfgSrcHeight = 2'd1,
    CfgDstWidth  = 2'd2,
    CfgDstHeight = 2'd3
  } bis_cfg_idx_e;

  localparam logic KindWrite = 1'b0;
  localparam logic KindQuery = 1'b1;

  // item riding along the pipeline
  typedef struct packed {
    logic              kind;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [PixW-1:0]   pixel;
    logic              wr_ok;
  } bis_item_t;

  typedef struct packed {
    logic              en;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [PixW-1:0]   data;
  } bis_wr_req_t;

  typedef struct packed {
    logic [CoordW-1:0] x0;
    logic [CoordW-1:0] x1;
    logic [CoordW-1:0] y0;
    logic [CoordW-1:0] y1;
  } bis_rd_req_t;

  typedef struct packed {
    logic [PixW-1:0] p00;
    logic [PixW-1:0] p10;
    logic [PixW-1:0] p01;
    logic [PixW-1:0] p11;
  } bis_quad_t;

endpackage

@@ src/bis_divider.sv @@
// ----------------------------------------------------------------------------
// bis_divider
// Pipelined restoring divider, two quotient bits per stage. Computes
// (num << SHIFT) / den; the caller guarantees the quotient fits QB bits.
// ----------------------------------------------------------------------------
module bis_divider
  import bis_pkg::*;
#(
  parameter int NUM_W = 20,
  parameter int SHIFT = 8,
  parameter int QB    = 16
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [CoordW-1:0] den_i,
  output logic [QB-1:0]     quo_o
);

  localparam int NW  = NUM_W + SHIFT;
  localparam int NS  = (QB + 1) / 2;
  localparam int QBP = 2 * NS;

  logic [NW-1:0]     n_full;
  logic [CoordW-1:0] rem0;
  logic [CoordW-1:0] rem_q [NS];
  logic [QBP-1:0]    low_q [NS];
  logic [QBP-1:0]    quo_q [NS];

  assign n_full = {num_i, {SHIFT{1'b0}}};
  // partial remainder above the quotient bits is below den by construction
  assign rem0   = CoordW'(n_full >> QBP);

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [CoordW-1:0] r_in;
    logic [CoordW-1:0] r_mid;
    logic [CoordW-1:0] r_out;
    logic [QBP-1:0]    l_in;
    logic [QBP-1:0]    q_in;
    logic [CoordW:0]   t0;
    logic [CoordW:0]   t1;
    logic              b0;
    logic              b1;

    if (s == 0) begin : g_first
      assign r_in = rem0;
      assign l_in = n_full[QBP-1:0];
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_q[s-1];
      assign l_in = low_q[s-1];
      assign q_in = quo_q[s-1];
    end

    always_comb begin
      t0    = {r_in, l_in[QBP-1]};
      b0    = (t0 >= {1'b0, den_i});
      r_mid = b0 ? CoordW'(t0 - {1'b0, den_i}) : t0[CoordW-1:0];
      t1    = {r_mid, l_in[QBP-2]};
      b1    = (t1 >= {1'b0, den_i});
      r_out = b1 ? CoordW'(t1 - {1'b0, den_i}) : t1[CoordW-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= r_out;
        low_q[s] <= {l_in[QBP-3:0], 2'b00};
        quo_q[s] <= {q_in[QBP-3:0], b0, b1};
      end
    end
  end

  assign quo_o = quo_q[NS-1][QB-1:0];

endmodule

@@ src/bis_frame_store.sv @@
// ----------------------------------------------------------------------------
// bis_frame_store
// Source frame split into four banks by column and row parity, so the four
// neighbours of a sample are read together, one per bank.
// ----------------------------------------------------------------------------
module bis_frame_store
  import bis_pkg::*;
#(
  parameter int MAX_W = DefMaxSrcWidth,
  parameter int MAX_H = DefMaxSrcHeight
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  bis_wr_req_t wr_i,
  input  bis_rd_req_t rd_i,
  output bis_quad_t   quad_o
);

  localparam int BankW = (MAX_W + 1) / 2;
  localparam int BankH = (MAX_H + 1) / 2;
  localparam int Depth = BankW * BankH;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

  logic [AW-1:0]   wa;
  logic [1:0]      wbank;
  logic [PixW-1:0] rdata [4];
  logic [3:0]      par_q;   // {y1, y0, x1, x0} parity

  assign wa    = AW'((wr_i.row >> 1) * BankW + (wr_i.col >> 1));
  assign wbank = {wr_i.row[0], wr_i.col[0]};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic XP = ((b % 2) == 1);
    localparam logic YP = ((b / 2) == 1);

    logic [PixW-1:0]   mem [Depth];
    logic [CoordW-1:0] rc;
    logic [CoordW-1:0] rr;
    logic [AW-1:0]     ra;
    logic [PixW-1:0]   rd_q;

    assign rc = (rd_i.x0[0] == XP) ? rd_i.x0 : rd_i.x1;
    assign rr = (rd_i.y0[0] == YP) ? rd_i.y0 : rd_i.y1;
    assign ra = AW'((rr >> 1) * BankW + (rc >> 1));

    always_ff @(posedge clk_i) begin
      if (en_i && wr_i.en && (wbank == 2'(b))) begin
        mem[wa] <= wr_i.data;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rd_q <= mem[ra];
      end
    end

    assign rdata[b] = rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      par_q <= {rd_i.y1[0], rd_i.y0[0], rd_i.x1[0], rd_i.x0[0]};
    end
  end

  // at the right or bottom edge x1 == x0, which selects the x0 bank again
  assign quad_o.p00 = rdata[{par_q[2], par_q[0]}];
  assign quad_o.p10 = rdata[{par_q[2], par_q[1]}];
  assign quad_o.p01 = rdata[{par_q[3], par_q[0]}];
  assign quad_o.p11 = rdata[{par_q[3], par_q[1]}];

endmodule

@@ src/bis_blend.sv @@
// ----------------------------------------------------------------------------
// bis_blend
// Horizontal blend of both rows (registered), then vertical blend with
// round half up. The vertical result is left for the output register.
// ----------------------------------------------------------------------------
module bis_blend
  import bis_pkg::*;
#(
  parameter int FRAC = DefFracBits
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  bis_quad_t       quad_i,
  input  logic [FRAC-1:0] fx_i,
  input  logic [FRAC-1:0] fy_i,
  output logic [PixW-1:0] value_o
);

  localparam int RowW = PixW + FRAC;
  localparam int MulW = RowW + 1;
  localparam int SumW = PixW + 2 * FRAC + 1;

  logic [FRAC:0]     wx0;
  logic [FRAC:0]     wx1;
  logic [MulW-1:0]   top_w;
  logic [MulW-1:0]   bot_w;
  logic [RowW-1:0]   top_q;
  logic [RowW-1:0]   bot_q;
  logic [FRAC-1:0]   fy_q;
  logic [FRAC:0]     wy0;
  logic [FRAC:0]     wy1;
  logic [SumW-1:0]   sum;
  logic [PixW:0]     rnd;

  assign wx0 = {1'b1, {FRAC{1'b0}}} - {1'b0, fx_i};
  assign wx1 = {1'b0, fx_i};

  assign top_w = MulW'(quad_i.p00) * MulW'(wx0) + MulW'(quad_i.p10) * MulW'(wx1);
  assign bot_w = MulW'(quad_i.p01) * MulW'(wx0) + MulW'(quad_i.p11) * MulW'(wx1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      top_q <= top_w[RowW-1:0];
      bot_q <= bot_w[RowW-1:0];
      fy_q  <= fy_i;
    end
  end

  assign wy0 = {1'b1, {FRAC{1'b0}}} - {1'b0, fy_q};
  assign wy1 = {1'b0, fy_q};

  assign sum = SumW'(top_q) * SumW'(wy0) + SumW'(bot_q) * SumW'(wy1)
             + (SumW'(1) << (2 * FRAC - 1));
  assign rnd = (PixW + 1)'(sum >> (2 * FRAC));

  assign value_o = rnd[PixW] ? {PixW{1'b1}} : rnd[PixW-1:0];

endmodule

@@ src/bilinear_image_scaler_unit.sv @@
// ----------------------------------------------------------------------------
// bilinear_image_scaler_unit
// Grayscale bilinear scaler: banked source frame store plus a pipeline that
// maps destination coordinates to the source and blends four neighbours.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i / in_stall_o): kind_i = 0 writes pixel_i to
//    the source frame at (col_i, row_i); kind_i = 1 requests the output
//    pixel at destination (col_i, row_i). Writes outside the store drop.
//  - Output channel (out_valid_o / out_stall_i): one result per query
//    request, none per write, in request order.
//  - Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
//    (src width, src height, dst width, dst height); write only when idle.
//  - Throughput: one request per cycle while the output is not stalled. The
//    pipeline runs from the input register through clamp and scale, the
//    coordinate divider (two quotient bits a stage), frame store access and
//    horizontal blend into the output register.
//  - A write and a later query reach the frame store in order, so a query
//    always sees every earlier write.
//  - Reset clears the pipeline valid bits and loads default registers; the
//    frame is undefined until written, with no clearing pass.
//  - While the output is stalled with a result pending, the whole pipeline
//    holds, bubbles included, and in_stall_o is raised.
// ----------------------------------------------------------------------------
module bilinear_image_scaler_unit
  import bis_pkg::*;
#(
  parameter int MAX_SRC_WIDTH  = DefMaxSrcWidth,
  parameter int MAX_SRC_HEIGHT = DefMaxSrcHeight,
  parameter int FRAC_BITS      = DefFracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  logic [CoordW-1:0]   col_i,
  input  logic [CoordW-1:0]   row_i,
  input  logic [PixW-1:0]     pixel_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CoordW-1:0]   out_col_o,
  output logic [CoordW-1:0]   out_row_o,
  output logic [PixW-1:0]     value_o
);

  localparam int IWX  = $clog2(MAX_SRC_WIDTH);
  localparam int IWY  = $clog2(MAX_SRC_HEIGHT);
  localparam int IW   = (IWX > IWY) ? IWX : IWY;
  localparam int NumW = CoordW + IW;
  localparam int QB   = IW + FRAC_BITS;
  localparam int NS   = (QB + 1) / 2;

  // configuration
  logic [SrcRegW-1:0] src_w_q, src_h_q;
  logic [DstRegW-1:0] dst_w_q, dst_h_q;
  logic [DstRegW-1:0] sw_c, sh_c, dw_c, dh_c;
  logic [IW-1:0]      sw_m1_q, sh_m1_q;
  logic [CoordW-1:0]  dw_m1_q, dh_m1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SrcWidthRst;
      src_h_q <= SrcHeightRst;
      dst_w_q <= DstWidthRst;
      dst_h_q <= DstHeightRst;
    end else if (cfg_we_i) begin
      unique case (bis_cfg_idx_e'(cfg_index_i))
        CfgSrcWidth:  src_w_q <= cfg_data_i[SrcRegW-1:0];
        CfgSrcHeight: src_h_q <= cfg_data_i[SrcRegW-1:0];
        CfgDstWidth:  dst_w_q <= cfg_data_i[DstRegW-1:0];
        CfgDstHeight: dst_h_q <= cfg_data_i[DstRegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sw_c = DstRegW'(src_w_q);
    if (sw_c < DstRegW'(2)) sw_c = DstRegW'(2);
    else if (sw_c > DstRegW'(MAX_SRC_WIDTH)) sw_c = DstRegW'(MAX_SRC_WIDTH);
    sh_c = DstRegW'(src_h_q);
    if (sh_c < DstRegW'(2)) sh_c = DstRegW'(2);
    else if (sh_c > DstRegW'(MAX_SRC_HEIGHT)) sh_c = DstRegW'(MAX_SRC_HEIGHT);
    dw_c = dst_w_q;
    if (dw_c < DstRegW'(2)) dw_c = DstRegW'(2);
    else if (dw_c > DstRegW'(DstMax)) dw_c = DstRegW'(DstMax);
    dh_c = dst_h_q;
    if (dh_c < DstRegW'(2)) dh_c = DstRegW'(2);
    else if (dh_c > DstRegW'(DstMax)) dh_c = DstRegW'(DstMax);
  end

  // derived limits, refreshed every cycle
  always_ff @(posedge clk_i) begin
    sw_m1_q <= IW'(sw_c - DstRegW'(1));
    sh_m1_q <= IW'(sh_c - DstRegW'(1));
    dw_m1_q <= CoordW'(dw_c - DstRegW'(1));
    dh_m1_q <= CoordW'(dh_c - DstRegW'(1));
  end

  // global advance: every pipeline stage holds while a result waits on a stall
  logic adv;
  logic out_valid_q;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // stage 0: input register
  logic      v0_q;
  bis_item_t it0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it0_q.kind  <= kind_i;
      it0_q.col   <= col_i;
      it0_q.row   <= row_i;
      it0_q.pixel <= pixel_i;
      it0_q.wr_ok <= 1'b0;
    end
  end

  // stage 1: clamp and scale by (src - 1)
  logic              v1_q;
  bis_item_t         it1_d, it1_q;
  logic [NumW-1:0]   numx_q, numy_q;
  logic [CoordW-1:0] cx, cy;

  always_comb begin
    cx = (it0_q.col > dw_m1_q) ? dw_m1_q : it0_q.col;
    cy = (it0_q.row > dh_m1_q) ? dh_m1_q : it0_q.row;
    it1_d       = it0_q;
    it1_d.wr_ok = (DstRegW'(it0_q.col) < DstRegW'(MAX_SRC_WIDTH)) &&
                  (DstRegW'(it0_q.row) < DstRegW'(MAX_SRC_HEIGHT));
    if (it0_q.kind == KindQuery) begin
      it1_d.col = cx;
      it1_d.row = cy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it1_q  <= it1_d;
      numx_q <= NumW'(cx) * NumW'(sw_m1_q);
      numy_q <= NumW'(cy) * NumW'(sh_m1_q);
    end
  end

  // divider stages, item rides alongside
  logic [QB-1:0] qx, qy;
  logic          dv_q  [NS];
  bis_item_t     dit_q [NS];

  bis_divider #(
    .NUM_W (NumW),
    .SHIFT (FRAC_BITS),
    .QB    (QB)
  ) u_div_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (numx_q),
    .den_i (dw_m1_q),
    .quo_o (qx)
  );

  bis_divider #(
    .NUM_W (NumW),
    .SHIFT (FRAC_BITS),
    .QB    (QB)
  ) u_div_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (numy_q),
    .den_i (dh_m1_q),
    .quo_o (qy)
  );

  for (genvar s = 0; s < NS; s++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[s] <= 1'b0;
      end else if (adv) begin
        dv_q[s] <= (s == 0) ? v1_q : dv_q[(s == 0) ? 0 : s - 1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dit_q[s] <= (s == 0) ? it1_q : dit_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  // stage A: neighbour indices, frame store access
  bis_item_t       itd;
  logic            vd;
  logic [IW-1:0]   x0_raw, y0_raw, x0c, y0c, x1, y1;
  logic [FRAC_BITS-1:0] fx, fy;
  bis_rd_req_t     rd_req;
  bis_wr_req_t     wr_req;
  bis_quad_t       quad;

  assign vd  = dv_q[NS-1];
  assign itd = dit_q[NS-1];

  always_comb begin
    x0_raw = qx[QB-1:FRAC_BITS];
    y0_raw = qy[QB-1:FRAC_BITS];
    fx     = qx[FRAC_BITS-1:0];
    fy     = qy[FRAC_BITS-1:0];
    x0c    = (x0_raw > sw_m1_q) ? sw_m1_q : x0_raw;
    y0c    = (y0_raw > sh_m1_q) ? sh_m1_q : y0_raw;
    x1     = (x0c < sw_m1_q) ? x0c + IW'(1) : x0c;
    y1     = (y0c < sh_m1_q) ? y0c + IW'(1) : y0c;
    rd_req.x0 = CoordW'(x0c);
    rd_req.x1 = CoordW'(x1);
    rd_req.y0 = CoordW'(y0c);
    rd_req.y1 = CoordW'(y1);
    wr_req.en   = vd && (itd.kind == KindWrite) && itd.wr_ok;
    wr_req.col  = itd.col;
    wr_req.row  = itd.row;
    wr_req.data = itd.pixel;
  end

  bis_frame_store #(
    .MAX_W (MAX_SRC_WIDTH),
    .MAX_H (MAX_SRC_HEIGHT)
  ) u_store (
    .clk_i  (clk_i),
    .en_i   (adv),
    .wr_i   (wr_req),
    .rd_i   (rd_req),
    .quad_o (quad)
  );

  logic                 va_q, vb_q;
  bis_item_t            ita_q, itb_q;
  logic [FRAC_BITS-1:0] fx_q, fy_q;
  logic [PixW-1:0]      blend_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      va_q        <= vd;
      vb_q        <= va_q;
      out_valid_q <= vb_q && (itb_q.kind == KindQuery);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ita_q <= itd;
      fx_q  <= fx;
      fy_q  <= fy;
      itb_q <= ita_q;
    end
  end

  // stage B inside the blend, stage C into the output register
  bis_blend #(
    .FRAC (FRAC_BITS)
  ) u_blend (
    .clk_i   (clk_i),
    .en_i    (adv),
    .quad_i  (quad),
    .fx_i    (fx_q),
    .fy_i    (fy_q),
    .value_o (blend_val)
  );

  logic [CoordW-1:0] out_col_q, out_row_q;
  logic [PixW-1:0]   value_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_col_q <= itb_q.col;
      out_row_q <= itb_q.row;
      value_q   <= blend_val;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_col_o   = out_col_q;
  assign out_row_o   = out_row_q;
  assign value_o     = value_q;

  // the reported coordinate was clamped to the destination
  a_out_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_col_o <= dw_m1_q) && (out_row_o <= dh_m1_q))
    else $error("output coordinate beyond destination size");

  // the mapped position never passes the last source column or row
  a_ipart_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vd && (itd.kind == KindQuery) |-> (x0_raw <= sw_m1_q) && (y0_raw <= sh_m1_q))
    else $error("integer part beyond source size");

  // on the last column or row the clamped neighbour must carry zero weight
  a_edge_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vd && (itd.kind == KindQuery) && ((x0c == sw_m1_q) || (y0c == sh_m1_q))
      |-> ((x0c != sw_m1_q) || (fx == '0)) && ((y0c != sh_m1_q) || (fy == '0)))
    else $error("nonzero weight on clamped neighbour");

  // a held pipeline keeps its stage valids
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(va_q) && $stable(vb_q) && $stable(v1_q))
    else $error("pipeline moved while stalled");

endmodule
